>>> rtl/core/cpq_pkg.sv
// package for the convex polyhedron query core: constants, codes and shared types
package cpq_pkg;
  localparam int MAX_VERTICES_DEF = 256;
  localparam int MAX_FACES_DEF = 256;
  localparam int COORD_BITS_DEF = 16;
  localparam int COUNT_BITS = 9;
  localparam int TOL_BITS = 20;
  localparam int INDEX_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [1:0] OP_WRITE_VERTEX = 2'd0;
  localparam logic [1:0] OP_WRITE_FACE = 2'd1;
  localparam logic [1:0] OP_SUPPORT = 2'd2;
  localparam logic [1:0] OP_INSIDE = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FACE_COUNT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME_TOL = 2'd2;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [INDEX_BITS-1:0] entry_index;
    logic [7:0] corner_a;
    logic [7:0] corner_b;
    logic [7:0] corner_c;
    logic signed [COORD_BITS_DEF-1:0] coord_x;
    logic signed [COORD_BITS_DEF-1:0] coord_y;
    logic signed [COORD_BITS_DEF-1:0] coord_z;
  } cmd_t;

  localparam int CMD_BITS = $bits(cmd_t);
endpackage

>>> rtl/core/cpq_ram.sv
// generic single-port-write, single-port-read ram with registered read
module cpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/cpq_front.sv
// front end: accepts items, decides refused writes, queues commands for the back end
module cpq_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cpq_pkg::cmd_t                   in_cmd,
  input  logic [cpq_pkg::COUNT_BITS-1:0]  live_vertices,
  input  logic [cpq_pkg::COUNT_BITS-1:0]  live_faces,
  output logic                            q_valid,
  input  logic                            q_ready,
  output cpq_pkg::cmd_t                   q_cmd,
  output logic                            q_refused
);
  localparam int DEPTH = 2;

  cpq_pkg::cmd_t slot_cmd [DEPTH];
  logic [DEPTH-1:0] slot_ref;
  logic wptr, rptr;
  logic [1:0] fill;
  logic refused;
  logic push, pop;

  always_comb begin
    refused = 1'b0;
    if (in_cmd.operation == cpq_pkg::OP_WRITE_VERTEX) begin
      refused = {1'b0, in_cmd.entry_index} >= live_vertices;
    end else if (in_cmd.operation == cpq_pkg::OP_WRITE_FACE) begin
      refused = {1'b0, in_cmd.entry_index} >= live_faces;
    end
  end

  assign in_ready = fill != 2'(DEPTH);
  assign push = in_valid && in_ready;
  assign q_valid = fill != 2'd0;
  assign pop = q_valid && q_ready;
  assign q_cmd = slot_cmd[rptr];
  assign q_refused = slot_ref[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_cmd[wptr] <= in_cmd;
      slot_ref[wptr] <= refused;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> rtl/core/cpq_back.sv
// back end: table writes, support walk and inside walk, with an output register
module cpq_back #(
  parameter int MAX_VERTICES = cpq_pkg::MAX_VERTICES_DEF,
  parameter int MAX_FACES = cpq_pkg::MAX_FACES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  cpq_pkg::cmd_t                   q_cmd,
  input  logic                            q_refused,
  input  logic [cpq_pkg::COUNT_BITS-1:0]  live_vertices,
  input  logic [cpq_pkg::COUNT_BITS-1:0]  live_faces,
  input  logic [cpq_pkg::TOL_BITS-1:0]    volume_tolerance,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            status,
  output logic                            is_inside,
  output logic [7:0]                      best_index,
  output logic signed [cpq_pkg::COORD_BITS_DEF-1:0] best_x,
  output logic signed [cpq_pkg::COORD_BITS_DEF-1:0] best_y,
  output logic signed [cpq_pkg::COORD_BITS_DEF-1:0] best_z
);
  localparam int VA = $clog2(MAX_VERTICES);
  localparam int FA = $clog2(MAX_FACES);
  localparam int CB = cpq_pkg::COORD_BITS_DEF;
  localparam int VW = 3 * CB;
  localparam int DOTW = 2 * CB + 2;
  localparam int EW = CB + 1;
  localparam int XW = 2 * EW + 1;
  localparam int VOLW = XW + EW + 2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUP = 4'd1;
  localparam logic [3:0] S_SUP_END = 4'd2;
  localparam logic [3:0] S_FACE_RD = 4'd3;
  localparam logic [3:0] S_V0 = 4'd4;
  localparam logic [3:0] S_V1 = 4'd5;
  localparam logic [3:0] S_V2 = 4'd6;
  localparam logic [3:0] S_CROSS = 4'd7;
  localparam logic [3:0] S_VOL = 4'd8;
  localparam logic [3:0] S_CMP = 4'd9;
  localparam logic [3:0] S_BEST_RD = 4'd10;
  localparam logic [3:0] S_BEST = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0] state;
  cpq_pkg::cmd_t cmd;
  logic [cpq_pkg::COUNT_BITS-1:0] cnt;
  logic [cpq_pkg::COUNT_BITS-1:0] sup_idx;
  logic [VA-1:0] best;
  logic signed [DOTW-1:0] best_dot, dp;
  logic rd_pend;
  logic [VA-1:0] rd_idx;
  logic [7:0] cc;
  logic ok0, ok1, ok2;
  logic signed [CB-1:0] v0x, v0y, v0z;
  logic signed [EW-1:0] ax, ay, az, bx, by, bz, dx, dy, dz;
  logic signed [XW-1:0] cx, cy, cz;
  logic signed [VOLW-1:0] vol;
  logic inside_r;

  logic v_we, f_we;
  logic [VA-1:0] v_raddr;
  logic [FA-1:0] f_raddr;
  logic [VW-1:0] v_rdata;
  logic [23:0] f_rdata;
  logic signed [CB-1:0] rx, ry, rz;

  assign rx = v_rdata[VW-1 -: CB];
  assign ry = v_rdata[2*CB-1 -: CB];
  assign rz = v_rdata[CB-1:0];

  assign q_ready = state == S_IDLE && !out_valid;
  assign v_we = q_valid && q_ready && !q_refused &&
                q_cmd.operation == cpq_pkg::OP_WRITE_VERTEX;
  assign f_we = q_valid && q_ready && !q_refused &&
                q_cmd.operation == cpq_pkg::OP_WRITE_FACE;

  cpq_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtab (
    .clk(clk), .we(v_we), .waddr(VA'(q_cmd.entry_index)),
    .wdata({CB'(q_cmd.coord_x), CB'(q_cmd.coord_y), CB'(q_cmd.coord_z)}),
    .raddr(v_raddr), .rdata(v_rdata));

  cpq_ram #(.WIDTH(24), .DEPTH(MAX_FACES)) u_ftab (
    .clk(clk), .we(f_we), .waddr(FA'(q_cmd.entry_index)),
    .wdata({q_cmd.corner_a, q_cmd.corner_b, q_cmd.corner_c}),
    .raddr(f_raddr), .rdata(f_rdata));

  always_comb begin
    v_raddr = VA'(sup_idx);
    case (state)
      S_FACE_RD: v_raddr = VA'(f_rdata[23:16]);
      S_V0: v_raddr = VA'(f_rdata[15:8]);
      S_V1: v_raddr = VA'(cc);
      S_BEST_RD: v_raddr = best;
      default: v_raddr = VA'(sup_idx);
    endcase
  end

  // face address leads the face walk: face 0 while idle, the next face in S_CMP
  always_comb begin
    case (state)
      S_IDLE: f_raddr = '0;
      S_CMP: f_raddr = FA'(cnt + 1'b1);
      default: f_raddr = FA'(cnt);
    endcase
  end

  assign dp = DOTW'(cmd.coord_x * rx) + DOTW'(cmd.coord_y * ry)
            + DOTW'(cmd.coord_z * rz);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cmd <= q_cmd;
            status <= q_refused;
            is_inside <= q_cmd.operation == cpq_pkg::OP_INSIDE && live_faces == '0;
            best_index <= 8'd0;
            best_x <= '0;
            best_y <= '0;
            best_z <= '0;
            cnt <= '0;
            sup_idx <= '0;
            rd_pend <= 1'b0;
            inside_r <= 1'b1;
            if (q_cmd.operation == cpq_pkg::OP_SUPPORT) begin
              state <= S_SUP;
            end else if (q_cmd.operation == cpq_pkg::OP_INSIDE) begin
              state <= (live_faces == '0) ? S_DONE : S_FACE_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SUP: begin
          rd_pend <= 1'b1;
          rd_idx <= VA'(sup_idx);
          if (rd_pend) begin
            if (rd_idx == '0 || dp > best_dot) begin
              best_dot <= dp;
              best <= rd_idx;
            end
          end
          if (sup_idx + 1'b1 >= live_vertices) begin
            state <= S_SUP_END;
          end else begin
            sup_idx <= sup_idx + 1'b1;
          end
        end
        S_SUP_END: begin
          if (rd_idx == '0 || dp > best_dot) begin
            best_dot <= dp;
            best <= rd_idx;
          end
          state <= S_BEST_RD;
        end
        S_BEST_RD: state <= S_BEST;
        S_BEST: begin
          best_index <= 8'(best);
          best_x <= rx;
          best_y <= ry;
          best_z <= rz;
          state <= S_DONE;
        end
        S_FACE_RD: begin
          cc <= f_rdata[7:0];
          ok0 <= int'(f_rdata[23:16]) < MAX_VERTICES;
          ok1 <= int'(f_rdata[15:8]) < MAX_VERTICES;
          ok2 <= int'(f_rdata[7:0]) < MAX_VERTICES;
          state <= S_V0;
        end
        S_V0: begin
          v0x <= ok0 ? rx : '0;
          v0y <= ok0 ? ry : '0;
          v0z <= ok0 ? rz : '0;
          dx <= EW'(cmd.coord_x) - EW'(ok0 ? rx : CB'(0));
          dy <= EW'(cmd.coord_y) - EW'(ok0 ? ry : CB'(0));
          dz <= EW'(cmd.coord_z) - EW'(ok0 ? rz : CB'(0));
          state <= S_V1;
        end
        S_V1: begin
          ax <= EW'(ok1 ? rx : CB'(0)) - EW'(v0x);
          ay <= EW'(ok1 ? ry : CB'(0)) - EW'(v0y);
          az <= EW'(ok1 ? rz : CB'(0)) - EW'(v0z);
          state <= S_V2;
        end
        S_V2: begin
          bx <= EW'(ok2 ? rx : CB'(0)) - EW'(v0x);
          by <= EW'(ok2 ? ry : CB'(0)) - EW'(v0y);
          bz <= EW'(ok2 ? rz : CB'(0)) - EW'(v0z);
          state <= S_CROSS;
        end
        S_CROSS: begin
          cx <= XW'(ay * bz) - XW'(az * by);
          cy <= XW'(az * bx) - XW'(ax * bz);
          cz <= XW'(ax * by) - XW'(ay * bx);
          state <= S_VOL;
        end
        S_VOL: begin
          vol <= VOLW'(dx * cx) + VOLW'(dy * cy) + VOLW'(dz * cz);
          state <= S_CMP;
        end
        S_CMP: begin
          if (vol > $signed({{(VOLW-cpq_pkg::TOL_BITS){1'b0}}, volume_tolerance})) begin
            is_inside <= 1'b0;
            state <= S_DONE;
          end else if (cnt + 1'b1 >= live_faces) begin
            is_inside <= 1'b1;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_FACE_RD;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/convex_polyhedron_query_core.sv
// top level of the convex polyhedron query core
// throughput: one item at a time in the back end; support walk reads one vertex per cycle,
// inside walk reads each face's three corners in turn on the single vertex table read port
// a two-entry queue lets the front end take items while the back end is busy
// synchronous reset restores register defaults; tables hold no defined contents until written
module convex_polyhedron_query_core #(
  parameter int MAX_VERTICES = cpq_pkg::MAX_VERTICES_DEF,
  parameter int MAX_FACES = cpq_pkg::MAX_FACES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [cpq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cpq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  entry_index,
  input  logic signed [cpq_pkg::COORD_BITS_DEF-1:0] coord_x,
  input  logic signed [cpq_pkg::COORD_BITS_DEF-1:0] coord_y,
  input  logic signed [cpq_pkg::COORD_BITS_DEF-1:0] coord_z,
  input  logic [7:0]  corner_a,
  input  logic [7:0]  corner_b,
  input  logic [7:0]  corner_c,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        is_inside,
  output logic [7:0]  best_index,
  output logic signed [cpq_pkg::COORD_BITS_DEF-1:0] best_x,
  output logic signed [cpq_pkg::COORD_BITS_DEF-1:0] best_y,
  output logic signed [cpq_pkg::COORD_BITS_DEF-1:0] best_z
);
  logic [cpq_pkg::COUNT_BITS-1:0] vertex_count, face_count, lv, lf;
  logic [cpq_pkg::TOL_BITS-1:0] volume_tolerance;
  cpq_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready, q_refused;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 9'd8;
      face_count <= 9'd12;
      volume_tolerance <= 20'd17;
    end else if (cfg_we) begin
      case (cfg_index)
        cpq_pkg::REG_VERTEX_COUNT: vertex_count <= cfg_data[8:0];
        cpq_pkg::REG_FACE_COUNT: face_count <= cfg_data[8:0];
        cpq_pkg::REG_VOLUME_TOL: volume_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lv = (vertex_count == '0) ? 9'd1 : vertex_count;
    if (int'(lv) > MAX_VERTICES) lv = 9'(MAX_VERTICES);
    lf = (int'(face_count) > MAX_FACES) ? 9'(MAX_FACES) : face_count;
  end

  assign in_cmd = '{operation: operation, entry_index: entry_index, corner_a: corner_a,
                    corner_b: corner_b, corner_c: corner_c, coord_x: coord_x,
                    coord_y: coord_y, coord_z: coord_z};

  cpq_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .live_vertices(lv), .live_faces(lf), .q_valid(q_valid), .q_ready(q_ready),
    .q_cmd(q_cmd), .q_refused(q_refused));

  cpq_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_FACES(MAX_FACES))
  u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .q_refused(q_refused), .live_vertices(lv), .live_faces(lf),
    .volume_tolerance(volume_tolerance), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .is_inside(is_inside), .best_index(best_index),
    .best_x(best_x), .best_y(best_y), .best_z(best_z));
endmodule
